// ===== rtl/core/mlrq_pkg.sv =====
// Shared types and constants for the multilevel ready queue.
// No dependencies; every other file in rtl/core except mlrq_ram takes names from here by scope.
`default_nettype none
package mlrq_pkg;

   localparam int ID_W      = 6;   // thread id field
   localparam int PRI_W     = 6;   // priority field
   localparam int CNT_W     = 7;   // ready count field
   localparam int ID_SPAN   = 2 ** ID_W;
   localparam int PRI_SPAN  = 2 ** PRI_W;
   localparam int LVL_IDX_W = PRI_W;

   localparam int LEVELS_DEF       = 64;
   localparam int THREAD_SLOTS_DEF = 64;

   // Level picker tree: groups of eight levels, then a pick over groups.
   localparam int GRP_SIZE = 8;
   localparam int GRP_W    = 3;

   localparam logic [CNT_W-1:0] CNT_MAX    = '1;
   localparam logic [1:0]       SETTLE_CYC = 2'd2;

   localparam logic CMD_ENQ = 1'b0;
   localparam logic CMD_DEQ = 1'b1;

   typedef enum logic [2:0] {
      ST_ENQ          = 3'd0,
      ST_DEQ          = 3'd1,
      ST_IDLE_GIVEN   = 3'd2,
      ST_REJECT       = 3'd3,
      ST_IDLE_IGNORED = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_LINK
   } state_type;

   typedef struct packed {
      logic                 any;
      logic [LVL_IDX_W-1:0] lvl;
   } pick_type;

   typedef struct packed {
      logic [ID_W-1:0]  chosen_id;
      status_type       status;
      logic [CNT_W-1:0] total;
   } rsp_type;

endpackage
`default_nettype wire

// ===== rtl/core/multilevel_ready_queue_top.sv =====
// Flow: an accepted request moves to the execute state, and its result beat is then held
//   in the response register. Requests are taken one at a time in the idle state; a
//   dequeue also passes the link state when the level keeps entries (the head's link is
//   read from the link RAM); after a mask change it waits for the registered level picker.
// Reset: synchronous; clears mask, queued flags, ready count and idle id. The level and
//   link RAMs are not cleared: the nonempty mask gates every use of their read data.
// Top level of the multilevel ready queue; depends on mlrq_pkg, mlrq_ram,
// mlrq_lvl_pick and mlrq_ctrl.
`default_nettype none
module multilevel_ready_queue_top #(
   parameter int LEVELS       = mlrq_pkg::LEVELS_DEF,
   parameter int THREAD_SLOTS = mlrq_pkg::THREAD_SLOTS_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // request channel
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic                         req_command,
   input  wire logic [mlrq_pkg::ID_W-1:0]    req_thread_id,
   input  wire logic [mlrq_pkg::PRI_W-1:0]   req_priority_req,
   // response channel
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic [mlrq_pkg::ID_W-1:0]    rsp_chosen_id,
   output      logic [2:0]                   rsp_status,
   output      logic [mlrq_pkg::CNT_W-1:0]   rsp_ready_total,
   // configuration write channel
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [mlrq_pkg::ID_W-1:0]    csr_idle_thread_id
);

   // The 6-bit priority and id fields cap how many levels and slots can ever be used.
   localparam int LEVELS_USED = (LEVELS < mlrq_pkg::PRI_SPAN) ? LEVELS : mlrq_pkg::PRI_SPAN;
   localparam int SLOTS_USED  = (THREAD_SLOTS < mlrq_pkg::ID_SPAN) ? THREAD_SLOTS
                                                                   : mlrq_pkg::ID_SPAN;
   localparam int LVL_W  = $clog2(LEVELS_USED);
   localparam int SLOT_W = $clog2(SLOTS_USED);
   localparam int ENTRY_W = 2 * mlrq_pkg::ID_W;   // {head, tail} per level

   logic [mlrq_pkg::ID_W-1:0]  idle_id_ff, idle_id_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   mlrq_pkg::rsp_type          rsp_ff, rsp_in;

   logic                       out_free;
   logic                       res_valid;
   mlrq_pkg::rsp_type          res;
   logic [LEVELS_USED-1:0]     mask;
   mlrq_pkg::pick_type         pick;

   logic                       lvl_we, lvl_re;
   logic [LVL_W-1:0]           lvl_waddr, lvl_raddr;
   logic [ENTRY_W-1:0]         lvl_wdata, lvl_rdata;
   logic                       link_we, link_re;
   logic [SLOT_W-1:0]          link_waddr, link_raddr;
   logic [mlrq_pkg::ID_W-1:0]  link_wdata, link_rdata;

   // Idle id taken each beat; software must write it only while quiet (not enforced).
   assign csr_ready  = 1'b1;
   assign idle_id_in = csr_valid ? csr_idle_thread_id : idle_id_ff;

   // The response register frees up on the same edge its beat leaves.
   assign out_free = !rsp_valid_ff || rsp_ready;

   // Load a new result from the sequencer, else drop the held one once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_id_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idle_id_ff   <= idle_id_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_chosen_id   = rsp_ff.chosen_id;
   assign rsp_status      = rsp_ff.status;
   assign rsp_ready_total = rsp_ff.total;

   // Per-level {head, tail} store.
   mlrq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (LEVELS_USED)
   ) u_level_ram (
      .clock (clock),
      .we    (lvl_we),
      .waddr (lvl_waddr),
      .wdata (lvl_wdata),
      .re    (lvl_re),
      .raddr (lvl_raddr),
      .rdata (lvl_rdata)
   );

   // Per-thread next link, chaining each level's FIFO.
   mlrq_ram #(
      .WIDTH (mlrq_pkg::ID_W),
      .DEPTH (SLOTS_USED)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .re    (link_re),
      .raddr (link_raddr),
      .rdata (link_rdata)
   );

   // Highest non-empty level, registered two stages behind the mask.
   mlrq_lvl_pick #(
      .LEVEL_COUNT (LEVELS_USED)
   ) u_lvl_pick (
      .clock (clock),
      .reset (reset),
      .mask  (mask),
      .pick  (pick)
   );

   mlrq_ctrl #(
      .LEVEL_COUNT (LEVELS_USED),
      .SLOT_COUNT  (SLOTS_USED)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_command      (req_command),
      .req_thread_id    (req_thread_id),
      .req_priority_req (req_priority_req),
      .out_free         (out_free),
      .idle_id          (idle_id_ff),
      .res_valid        (res_valid),
      .res              (res),
      .mask             (mask),
      .pick             (pick),
      .lvl_we           (lvl_we),
      .lvl_waddr        (lvl_waddr),
      .lvl_wdata        (lvl_wdata),
      .lvl_re           (lvl_re),
      .lvl_raddr        (lvl_raddr),
      .lvl_rdata        (lvl_rdata),
      .link_we          (link_we),
      .link_waddr       (link_waddr),
      .link_wdata       (link_wdata),
      .link_re          (link_re),
      .link_raddr       (link_raddr),
      .link_rdata       (link_rdata)
   );

endmodule
`default_nettype wire

// ===== rtl/core/mlrq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none
module mlrq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output      logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

// ===== rtl/core/mlrq_lvl_pick.sv =====
// Two-stage registered search for the highest non-empty priority level.
// Depends on mlrq_pkg (pick_type, group constants).
`default_nettype none
module mlrq_lvl_pick #(
   parameter int LEVEL_COUNT = mlrq_pkg::LEVELS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [LEVEL_COUNT-1:0] mask,
   output      mlrq_pkg::pick_type     pick
);

   localparam int GROUP_COUNT = (LEVEL_COUNT + mlrq_pkg::GRP_SIZE - 1) / mlrq_pkg::GRP_SIZE;
   localparam int PAD_W       = GROUP_COUNT * mlrq_pkg::GRP_SIZE;

   logic [PAD_W-1:0]                             mask_pad;
   logic [GROUP_COUNT-1:0]                       grp_any_ff, grp_any_in;
   logic [GROUP_COUNT-1:0][mlrq_pkg::GRP_W-1:0]  grp_sub_ff, grp_sub_in;
   mlrq_pkg::pick_type                           pick_ff, pick_in;

   assign mask_pad = PAD_W'(mask);

   // stage one: highest set bit inside each group
   always_comb begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
         grp_any_in[g] = |mask_pad[g*mlrq_pkg::GRP_SIZE +: mlrq_pkg::GRP_SIZE];
         grp_sub_in[g] = '0;
         for (int b = 0; b < mlrq_pkg::GRP_SIZE; b++) begin
            if (mask_pad[g*mlrq_pkg::GRP_SIZE + b]) begin
               grp_sub_in[g] = mlrq_pkg::GRP_W'(b);
            end
         end
      end
   end

   // stage two: highest non-empty group
   always_comb begin
      pick_in.any = |grp_any_ff;
      pick_in.lvl = '0;
      for (int g = 0; g < GROUP_COUNT; g++) begin
         if (grp_any_ff[g]) begin
            pick_in.lvl = {mlrq_pkg::GRP_W'(g), grp_sub_ff[g]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grp_any_ff <= '0;
         pick_ff    <= '0;
      end else begin
         grp_any_ff <= grp_any_in;
         pick_ff    <= pick_in;
      end
      grp_sub_ff <= grp_sub_in;
   end

   assign pick = pick_ff;

endmodule
`default_nettype wire

// ===== rtl/core/mlrq_ctrl.sv =====
// Sequencer for the ready queue: level and link RAM read-modify-write,
// nonempty mask, queued flags and ready count. Depends on mlrq_pkg.
`default_nettype none
module mlrq_ctrl #(
   parameter int LEVEL_COUNT = mlrq_pkg::LEVELS_DEF,
   parameter int SLOT_COUNT  = mlrq_pkg::THREAD_SLOTS_DEF,
   localparam int LVL_W      = $clog2(LEVEL_COUNT),
   localparam int SLOT_W     = $clog2(SLOT_COUNT)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire logic                         req_command,
   input  wire logic [mlrq_pkg::ID_W-1:0]    req_thread_id,
   input  wire logic [mlrq_pkg::PRI_W-1:0]   req_priority_req,
   input  wire logic                         out_free,
   input  wire logic [mlrq_pkg::ID_W-1:0]    idle_id,
   output      logic                         res_valid,
   output      mlrq_pkg::rsp_type            res,
   output      logic [LEVEL_COUNT-1:0]       mask,
   input  wire mlrq_pkg::pick_type           pick,
   output      logic                         lvl_we,
   output      logic [LVL_W-1:0]             lvl_waddr,
   output      logic [2*mlrq_pkg::ID_W-1:0]  lvl_wdata,
   output      logic                         lvl_re,
   output      logic [LVL_W-1:0]             lvl_raddr,
   input  wire logic [2*mlrq_pkg::ID_W-1:0]  lvl_rdata,
   output      logic                         link_we,
   output      logic [SLOT_W-1:0]            link_waddr,
   output      logic [mlrq_pkg::ID_W-1:0]    link_wdata,
   output      logic                         link_re,
   output      logic [SLOT_W-1:0]            link_raddr,
   input  wire logic [mlrq_pkg::ID_W-1:0]    link_rdata
);

   localparam int LVL_LAST = LEVEL_COUNT - 1;

   mlrq_pkg::state_type             state_ff, state_in;
   logic                            cmd_ff, cmd_in;
   logic [mlrq_pkg::ID_W-1:0]       id_ff, id_in;
   logic [LVL_W-1:0]                lvl_ff, lvl_in;
   logic                            any_ff, any_in;
   logic [mlrq_pkg::ID_W-1:0]       tail_ff, tail_in;
   logic [LEVEL_COUNT-1:0]          mask_ff, mask_in;
   logic [SLOT_COUNT-1:0]           flag_ff, flag_in;
   logic [mlrq_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [1:0]                      settle_ff, settle_in;

   logic                            fire;
   logic [mlrq_pkg::PRI_W-1:0]      pri_sat;
   logic [LVL_W-1:0]                lvl_sel;
   logic [mlrq_pkg::ID_W-1:0]       head_rd, tail_rd;
   logic                            in_range, flag_hit, enq_idle, enq_ok;
   logic                            lvl_busy, deq_last, deq_link, deq_take, mask_we;

   // ---- accept and level selection ----
   assign req_ready = (state_ff == mlrq_pkg::S_IDLE) && out_free &&
                      ((settle_ff == 2'd0) || (req_command == mlrq_pkg::CMD_ENQ));
   assign fire      = req_valid && req_ready;

   assign pri_sat = ({1'b0, req_priority_req} >= 7'(LEVEL_COUNT)) ?
                    mlrq_pkg::PRI_W'(LVL_LAST) : req_priority_req;
   assign lvl_sel = (req_command == mlrq_pkg::CMD_ENQ) ? pri_sat[LVL_W-1:0]
                                                        : pick.lvl[LVL_W-1:0];

   // ---- decode of the level entry read back ----
   assign head_rd  = lvl_rdata[2*mlrq_pkg::ID_W-1:mlrq_pkg::ID_W];
   assign tail_rd  = lvl_rdata[mlrq_pkg::ID_W-1:0];
   assign in_range = ({1'b0, id_ff} < 7'(SLOT_COUNT));
   assign flag_hit = in_range ? flag_ff[id_ff[SLOT_W-1:0]] : 1'b0;
   assign enq_idle = (id_ff == idle_id);
   assign enq_ok   = !enq_idle && in_range && !flag_hit;
   assign lvl_busy = mask_ff[lvl_ff];
   assign deq_last = (head_rd == tail_rd);
   assign deq_take = (state_ff == mlrq_pkg::S_EXEC) && (cmd_ff == mlrq_pkg::CMD_DEQ) && any_ff;
   assign deq_link = deq_take && !deq_last;
   assign mask_we  = (state_ff == mlrq_pkg::S_EXEC) &&
                     (((cmd_ff == mlrq_pkg::CMD_ENQ) && enq_ok && !lvl_busy) ||
                      (deq_take && deq_last));

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mlrq_pkg::S_IDLE: begin
            if (fire) begin
               state_in = mlrq_pkg::S_EXEC;
            end
         end
         mlrq_pkg::S_EXEC: begin
            state_in = deq_link ? mlrq_pkg::S_LINK : mlrq_pkg::S_IDLE;
         end
         mlrq_pkg::S_LINK: begin
            state_in = mlrq_pkg::S_IDLE;
         end
         default: begin
            state_in = mlrq_pkg::S_IDLE;
         end
      endcase
   end

   // ---- state outputs: memory ports and result ----
   always_comb begin
      lvl_re        = 1'b0;
      lvl_raddr     = lvl_sel;
      lvl_we        = 1'b0;
      lvl_waddr     = lvl_ff;
      lvl_wdata     = {id_ff, id_ff};
      link_we       = 1'b0;
      link_waddr    = tail_rd[SLOT_W-1:0];
      link_wdata    = id_ff;
      link_re       = 1'b0;
      link_raddr    = head_rd[SLOT_W-1:0];
      res_valid     = 1'b0;
      res.chosen_id = '0;
      res.status    = mlrq_pkg::ST_ENQ;
      res.total     = count_in;
      unique case (state_ff)
         mlrq_pkg::S_IDLE: begin
            lvl_re = fire;
         end
         mlrq_pkg::S_EXEC: begin
            res_valid = 1'b1;
            if (cmd_ff == mlrq_pkg::CMD_ENQ) begin
               if (enq_idle) begin
                  res.status = mlrq_pkg::ST_IDLE_IGNORED;
               end else if (!enq_ok) begin
                  res.status = mlrq_pkg::ST_REJECT;
               end else begin
                  lvl_we    = 1'b1;
                  lvl_wdata = {(lvl_busy ? head_rd : id_ff), id_ff};
                  link_we   = lvl_busy;
               end
            end else if (any_ff) begin
               res.chosen_id = head_rd;
               res.status    = mlrq_pkg::ST_DEQ;
               link_re       = deq_link;
            end else begin
               res.chosen_id = idle_id;
               res.status    = mlrq_pkg::ST_IDLE_GIVEN;
            end
         end
         mlrq_pkg::S_LINK: begin
            lvl_we    = 1'b1;
            lvl_wdata = {link_rdata, tail_ff};
         end
         default: begin
            lvl_re = 1'b0;
         end
      endcase
   end

   // ---- datapath registers ----
   always_comb begin
      cmd_in    = cmd_ff;
      id_in     = id_ff;
      lvl_in    = lvl_ff;
      any_in    = any_ff;
      tail_in   = tail_ff;
      mask_in   = mask_ff;
      flag_in   = flag_ff;
      count_in  = count_ff;
      settle_in = (settle_ff != 2'd0) ? settle_ff - 2'd1 : settle_ff;

      if (fire) begin
         cmd_in = req_command;
         id_in  = req_thread_id;
         lvl_in = lvl_sel;
         any_in = pick.any;
      end

      if (state_ff == mlrq_pkg::S_EXEC) begin
         tail_in = tail_rd;
         if ((cmd_ff == mlrq_pkg::CMD_ENQ) && enq_ok) begin
            mask_in[lvl_ff]               = 1'b1;
            flag_in[id_ff[SLOT_W-1:0]]    = 1'b1;
            count_in = (count_ff == mlrq_pkg::CNT_MAX) ? count_ff : count_ff + 1'b1;
         end
         if (deq_take) begin
            if (deq_last) begin
               mask_in[lvl_ff] = 1'b0;
            end
            flag_in[head_rd[SLOT_W-1:0]] = 1'b0;
            count_in = (count_ff == '0) ? count_ff : count_ff - 1'b1;
         end
      end

      // hold dequeues until the level picker has seen the new mask
      if (mask_we) begin
         settle_in = mlrq_pkg::SETTLE_CYC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mlrq_pkg::S_IDLE;
         mask_ff   <= '0;
         flag_ff   <= '0;
         count_ff  <= '0;
         settle_ff <= '0;
      end else begin
         state_ff  <= state_in;
         mask_ff   <= mask_in;
         flag_ff   <= flag_in;
         count_ff  <= count_in;
         settle_ff <= settle_in;
      end
      cmd_ff  <= cmd_in;
      id_ff   <= id_in;
      lvl_ff  <= lvl_in;
      any_ff  <= any_in;
      tail_ff <= tail_in;
   end

   assign mask = mask_ff;

`ifndef SYNTHESIS
   a_count_matches_flags: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) == $countones(flag_ff))
      else $error("ready count differs from queued flag population");

   a_deq_was_queued: assert property (@(posedge clock) disable iff (reset)
      res_valid && res.status == mlrq_pkg::ST_DEQ |-> flag_ff[head_rd[SLOT_W-1:0]])
      else $error("dequeued id was not marked queued");

   a_enq_sets_mask: assert property (@(posedge clock) disable iff (reset)
      state_ff == mlrq_pkg::S_EXEC && cmd_ff == mlrq_pkg::CMD_ENQ && enq_ok
      |=> mask_ff[$past(lvl_ff)])
      else $error("enqueue left its level marked empty");

   a_link_after_deq: assert property (@(posedge clock) disable iff (reset)
      state_ff == mlrq_pkg::S_LINK
      |-> $past(state_ff) == mlrq_pkg::S_EXEC && $past(cmd_ff) == mlrq_pkg::CMD_DEQ)
      else $error("link write-back outside a dequeue");
`endif

endmodule
`default_nettype wire
